// ===== rtl/core/scg3d_pkg.sv =====
`default_nettype none
package scg3d_pkg;

	localparam int FORCE_WIDTH = 24;
	localparam int WEIGHT_FRAC = 16;
	localparam int WMAG_W      = WEIGHT_FRAC + 1;
	localparam int WT_W        = WMAG_W + 1;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam logic [PADDR_W-1:0] REG_GRID_X = 4'h0;
	localparam logic [PADDR_W-1:0] REG_GRID_Y = 4'h4;
	localparam logic [PADDR_W-1:0] REG_GRID_Z = 4'h8;
	localparam logic [PADDR_W-1:0] REG_WINDOW = 4'hC;

	localparam logic [6:0] GRID_X_RST = 7'd64;
	localparam logic [6:0] GRID_Y_RST = 7'd64;
	localparam logic [6:0] GRID_Z_RST = 7'd40;
	localparam logic [2:0] WINDOW_RST = 3'd2;

	typedef struct packed {
		logic signed [FORCE_WIDTH-1:0] force_x;
		logic signed [FORCE_WIDTH-1:0] force_y;
		logic signed [FORCE_WIDTH-1:0] force_z;
		logic                          first_site;
	} force_word_t;

	typedef struct packed {
		logic signed [FORCE_WIDTH-1:0] stress_xx;
		logic signed [FORCE_WIDTH-1:0] stress_xy;
		logic signed [FORCE_WIDTH-1:0] stress_xz;
		logic signed [FORCE_WIDTH-1:0] stress_yy;
		logic signed [FORCE_WIDTH-1:0] stress_yz;
		logic signed [FORCE_WIDTH-1:0] stress_zz;
		logic                          last_cell;
	} stress_word_t;

	typedef struct packed {
		logic wr;
		logic acc_clr;
		logic rd;
		logic div_load;
		logic div_init;
		logic div_step;
		logic out_load;
		logic last_cell;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_full;
	} status_t;

	// |p| * 2^16 / |(p,q,r)|, rounded half away from zero; elaboration only
	function automatic int unit_weight(int p, int q, int r);
		longint unsigned s;
		longint unsigned ap;
		longint unsigned t;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		s  = longint'(p * p + q * q + r * r);
		ap = longint'(p < 0 ? -p : p);
		lo = 0;
		hi = 64'd1 << WEIGHT_FRAC;
		if (s == 0 || ap == 0) begin
			return 0;
		end
		t = (ap * ap) << (2 * WEIGHT_FRAC);
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * s <= t) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		if ((2 * lo + 1) * (2 * lo + 1) * s <= (t << 2)) begin
			lo = lo + 1;
		end
		return int'(lo);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scg3d_div.sv =====
`default_nettype none
module scg3d_div #(
	parameter int ACC_W = 52,
	parameter int VOL_W = 7
) (
	input  logic                                  clk,
	input  scg3d_pkg::cmd_t                       cmd,
	input  logic signed [ACC_W-1:0]               acc,
	input  logic                                  off_diag,
	input  logic [VOL_W-1:0]                      vol,
	output logic signed [scg3d_pkg::FORCE_WIDTH-1:0] result
);
	import scg3d_pkg::*;

	localparam int FW = FORCE_WIDTH;
	localparam int TW = ACC_W + 1 - WEIGHT_FRAC;
	localparam logic [FW-1:0] LIM = FW'(1) << (FW - 1);

	logic [ACC_W-1:0] mag;
	logic [ACC_W:0]   rnd_sum;
	logic [TW-1:0]    t_next;
	logic [TW-1:0]    t_q;
	logic             neg_q;
	logic             sat_q;
	logic [VOL_W-1:0] rem_q;
	logic [FW-1:0]    quo_q;
	logic [VOL_W:0]   dvd;
	logic [FW-1:0]    neg_quo;

	// round on the power-of-two part first, then divide by the volume
	always_comb begin
		mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		if (off_diag) begin
			rnd_sum = (ACC_W+1)'(mag) + ((ACC_W+1)'(vol) << WEIGHT_FRAC);
			t_next  = TW'(rnd_sum >> (WEIGHT_FRAC + 1));
		end else begin
			rnd_sum = (ACC_W+1)'(mag) + ((ACC_W+1)'(vol) << (WEIGHT_FRAC - 1));
			t_next  = TW'(rnd_sum >> WEIGHT_FRAC);
		end
		dvd     = {rem_q, quo_q[FW-1]};
		neg_quo = FW'(-quo_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			t_q   <= t_next;
			neg_q <= acc[ACC_W-1];
		end
		if (cmd.div_init) begin
			sat_q <= t_q >= (TW'(vol) << FW);
			rem_q <= t_q[FW +: VOL_W];
			quo_q <= t_q[FW-1:0];
		end else if (cmd.div_step) begin
			if (dvd >= {1'b0, vol}) begin
				rem_q <= VOL_W'(dvd - {1'b0, vol});
				quo_q <= {quo_q[FW-2:0], 1'b1};
			end else begin
				rem_q <= VOL_W'(dvd);
				quo_q <= {quo_q[FW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			result = (sat_q || quo_q > LIM) ? signed'(LIM) : signed'(neg_quo);
		end else begin
			result = (sat_q || quo_q >= LIM) ? signed'(LIM - 1'b1) : signed'(quo_q);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/scg3d_ctrl.sv =====
`default_nettype none
module scg3d_ctrl #(
	parameter int MAX_SIDE_X = 64,
	parameter int MAX_SIDE_Y = 64,
	parameter int MAX_SIDE_Z = 64,
	parameter int MAX_WINDOW = 4
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     force_valid,
	output logic                                     force_ready,
	input  logic                                     first_site,
	input  logic                                     stress_ready,
	input  logic [$clog2(MAX_SIDE_X+1)-1:0]          gx,
	input  logic [$clog2(MAX_SIDE_Y+1)-1:0]          gy,
	input  logic [$clog2(MAX_SIDE_Z+1)-1:0]          gz,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]          n,
	input  scg3d_pkg::status_t                       st,
	output scg3d_pkg::cmd_t                          cmd,
	output logic [$clog2(MAX_SIDE_X)-1:0]            wr_x,
	output logic [$clog2(MAX_SIDE_Y)-1:0]            wr_y,
	output logic [$clog2(MAX_WINDOW)-1:0]            wr_zr,
	output logic [$clog2(MAX_SIDE_X)-1:0]            rd_x,
	output logic [$clog2(MAX_SIDE_Y)-1:0]            rd_y,
	output logic [$clog2(MAX_WINDOW)-1:0]            rd_zr,
	output logic signed [$clog2(MAX_WINDOW):0]       off_a,
	output logic signed [$clog2(MAX_WINDOW):0]       off_b,
	output logic signed [$clog2(MAX_WINDOW):0]       off_c
);
	import scg3d_pkg::*;

	localparam int XW  = $clog2(MAX_SIDE_X);
	localparam int YW  = $clog2(MAX_SIDE_Y);
	localparam int ZW  = $clog2(MAX_SIDE_Z);
	localparam int ZRW = $clog2(MAX_WINDOW);
	localparam int OFW = ZRW + 1;
	localparam int SW  = $clog2(FORCE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_LOAD,
		ST_INIT,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t         state_q;
	logic [XW-1:0]  pos_x_q;
	logic [YW-1:0]  pos_y_q;
	logic [ZW-1:0]  pos_z_q;
	logic [ZRW-1:0] pos_zr_q;
	logic [XW-1:0]  x0_q;
	logic [YW-1:0]  y0_q;
	logic [ZRW-1:0] zr_rd_q;
	logic [ZRW-1:0] dx_q;
	logic [ZRW-1:0] dy_q;
	logic [ZRW-1:0] dz_q;
	logic           last_q;
	logic [SW-1:0]  step_q;

	logic [XW-1:0]  px_raw, px, nxt_x, win_x0;
	logic [YW-1:0]  py_raw, py, nxt_y, win_y0;
	logic [ZW-1:0]  pz_raw, pz, nxt_z;
	logic [ZRW-1:0] pzr, nxt_zr, win_zr0, nm1;
	logic           need, last, y_wrap, x_wrap, z_wrap, accept;

	always_comb begin
		nm1    = ZRW'(n - 1'b1);
		px_raw = first_site ? '0 : pos_x_q;
		py_raw = first_site ? '0 : pos_y_q;
		pz_raw = first_site ? '0 : pos_z_q;
		px     = (int'(px_raw) >= int'(gx)) ? '0 : px_raw;
		py     = (int'(py_raw) >= int'(gy)) ? '0 : py_raw;
		pz     = (int'(pz_raw) >= int'(gz)) ? '0 : pz_raw;
		pzr    = (first_site || int'(pos_z_q) >= int'(gz)) ? '0 : pos_zr_q;
		need   = int'(px) >= int'(nm1) && int'(py) >= int'(nm1) && int'(pz) >= int'(nm1);
		last   = int'(px) == int'(gx) - 1 && int'(py) == int'(gy) - 1
			&& int'(pz) == int'(gz) - 1;
		win_x0 = XW'(int'(px) - int'(nm1));
		win_y0 = YW'(int'(py) - int'(nm1));
		if (int'(pzr) < int'(nm1)) begin
			win_zr0 = ZRW'(int'(pzr) + MAX_WINDOW - int'(nm1));
		end else begin
			win_zr0 = ZRW'(int'(pzr) - int'(nm1));
		end
		y_wrap = int'(py) + 1 >= int'(gy);
		x_wrap = int'(px) + 1 >= int'(gx);
		z_wrap = int'(pz) + 1 >= int'(gz);
		nxt_y  = y_wrap ? '0 : py + 1'b1;
		nxt_x  = y_wrap ? (x_wrap ? '0 : px + 1'b1) : px;
		nxt_z  = (y_wrap && x_wrap) ? (z_wrap ? '0 : pz + 1'b1) : pz;
		if (y_wrap && x_wrap) begin
			if (z_wrap || int'(pzr) + 1 >= MAX_WINDOW) begin
				nxt_zr = '0;
			end else begin
				nxt_zr = pzr + 1'b1;
			end
		end else begin
			nxt_zr = pzr;
		end
	end

	assign force_ready = (state_q == ST_IDLE);
	assign accept      = force_valid && force_ready;

	always_comb begin
		cmd           = '0;
		cmd.wr        = accept;
		cmd.acc_clr   = accept && need;
		cmd.rd        = (state_q == ST_READ);
		cmd.div_load  = (state_q == ST_LOAD);
		cmd.div_init  = (state_q == ST_INIT);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.out_load  = (state_q == ST_OUT) && (!st.out_full || stress_ready);
		cmd.last_cell = last_q;
	end

	assign wr_x  = px;
	assign wr_y  = py;
	assign wr_zr = pzr;
	assign rd_x  = x0_q + XW'(dx_q);
	assign rd_y  = y0_q + YW'(dy_q);
	assign rd_zr = zr_rd_q;
	assign off_a = OFW'(int'(nm1) - 2 * int'(dx_q));
	assign off_b = OFW'(int'(nm1) - 2 * int'(dy_q));
	assign off_c = OFW'(int'(nm1) - 2 * int'(dz_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			pos_z_q  <= '0;
			pos_zr_q <= '0;
			x0_q     <= '0;
			y0_q     <= '0;
			zr_rd_q  <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			dz_q     <= '0;
			last_q   <= 1'b0;
			step_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_x_q  <= nxt_x;
						pos_y_q  <= nxt_y;
						pos_z_q  <= nxt_z;
						pos_zr_q <= nxt_zr;
						x0_q     <= win_x0;
						y0_q     <= win_y0;
						zr_rd_q  <= win_zr0;
						last_q   <= last;
						dx_q     <= '0;
						dy_q     <= '0;
						dz_q     <= '0;
						if (need) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (dy_q == nm1) begin
						dy_q <= '0;
						if (dx_q == nm1) begin
							dx_q <= '0;
							dz_q <= dz_q + 1'b1;
							zr_rd_q <= (int'(zr_rd_q) + 1 >= MAX_WINDOW) ? '0 : zr_rd_q + 1'b1;
							if (dz_q == nm1) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							dx_q <= dx_q + 1'b1;
						end
					end else begin
						dy_q <= dy_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!st.pipe_busy) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (int'(step_q) == FORCE_WIDTH - 1) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!st.out_full || stress_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!st.out_full || stress_ready))
		else $error("result loaded over a word not yet taken");

	a_div_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> !st.pipe_busy)
		else $error("divide started before accumulation finished");

	a_clr_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_clr |=> cmd.rd)
		else $error("window read did not follow accumulator clear");

endmodule
`default_nettype wire

// ===== rtl/core/scg3d_dp.sv =====
`default_nettype none
module scg3d_dp #(
	parameter int MAX_SIDE_X = 64,
	parameter int MAX_SIDE_Y = 64,
	parameter int MAX_WINDOW = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scg3d_pkg::cmd_t                      cmd,
	output scg3d_pkg::status_t                   st,
	input  scg3d_pkg::force_word_t               force_word,
	input  logic [$clog2(MAX_SIDE_X)-1:0]        wr_x,
	input  logic [$clog2(MAX_SIDE_Y)-1:0]        wr_y,
	input  logic [$clog2(MAX_WINDOW)-1:0]        wr_zr,
	input  logic [$clog2(MAX_SIDE_X)-1:0]        rd_x,
	input  logic [$clog2(MAX_SIDE_Y)-1:0]        rd_y,
	input  logic [$clog2(MAX_WINDOW)-1:0]        rd_zr,
	input  logic signed [$clog2(MAX_WINDOW):0]   off_a,
	input  logic signed [$clog2(MAX_WINDOW):0]   off_b,
	input  logic signed [$clog2(MAX_WINDOW):0]   off_c,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]      n,
	input  logic                                 stress_ready,
	output logic                                 stress_valid,
	output scg3d_pkg::stress_word_t              stress_word
);
	import scg3d_pkg::*;

	localparam int FW     = FORCE_WIDTH;
	localparam int ZRW    = $clog2(MAX_WINDOW);
	localparam int OFW    = ZRW + 1;
	localparam int CUBE   = MAX_WINDOW * MAX_WINDOW * MAX_WINDOW;
	localparam int IXW    = $clog2(CUBE);
	localparam int VOL_W  = $clog2(CUBE + 1);
	localparam int PW     = FW + WT_W;
	localparam int ACC_W  = PW + 1 + $clog2(CUBE);
	localparam int PLANE  = MAX_SIDE_X * MAX_SIDE_Y;
	localparam int DEPTH  = MAX_WINDOW * PLANE;
	localparam int AW     = $clog2(DEPTH);

	typedef logic [WMAG_W-1:0] wtab_t [CUBE];

	function automatic wtab_t build_wtab();
		wtab_t tab;
		for (int a = 0; a < MAX_WINDOW; a++) begin
			for (int b = 0; b < MAX_WINDOW; b++) begin
				for (int c = 0; c < MAX_WINDOW; c++) begin
					tab[(a * MAX_WINDOW + b) * MAX_WINDOW + c] = WMAG_W'(unit_weight(a, b, c));
				end
			end
		end
		return tab;
	endfunction

	localparam wtab_t WTAB = build_wtab();

	function automatic logic signed [WT_W-1:0] wgt(logic signed [OFW-1:0] p,
		logic signed [OFW-1:0] q, logic signed [OFW-1:0] r);
		logic [ZRW-1:0]         ap;
		logic [ZRW-1:0]         aq;
		logic [ZRW-1:0]         ar;
		logic [IXW-1:0]         idx;
		logic signed [WT_W-1:0] m;
		ap  = (p < 0) ? ZRW'(-p) : ZRW'(p);
		aq  = (q < 0) ? ZRW'(-q) : ZRW'(q);
		ar  = (r < 0) ? ZRW'(-r) : ZRW'(r);
		idx = IXW'((int'(ap) * MAX_WINDOW + int'(aq)) * MAX_WINDOW + int'(ar));
		m   = signed'({1'b0, WTAB[idx]});
		return (p < 0) ? -m : m;
	endfunction

	logic [3*FW-1:0] ring_mem [DEPTH];
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;

	logic [3*FW-1:0]        site_s1;
	logic signed [WT_W-1:0] ux_s1, uy_s1, uz_s1;
	logic                   v_s1;
	logic signed [FW-1:0]   fx_s1, fy_s1, fz_s1;

	logic signed [PW-1:0] pxx_s2, pxy1_s2, pxy2_s2, pxz1_s2, pxz2_s2;
	logic signed [PW-1:0] pyy_s2, pyz1_s2, pyz2_s2, pzz_s2;
	logic                 v_s2;

	logic signed [ACC_W-1:0] acc_xx_q, acc_xy_q, acc_xz_q, acc_yy_q, acc_yz_q, acc_zz_q;
	logic [VOL_W-1:0]        vol;
	logic signed [FW-1:0]    r_xx, r_xy, r_xz, r_yy, r_yz, r_zz;
	logic                    out_valid_q;
	stress_word_t            out_q;

	assign wr_addr = AW'(wr_zr) * AW'(PLANE) + AW'(wr_x) * AW'(MAX_SIDE_Y) + AW'(wr_y);
	assign rd_addr = AW'(rd_zr) * AW'(PLANE) + AW'(rd_x) * AW'(MAX_SIDE_Y) + AW'(rd_y);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			ring_mem[wr_addr] <= {force_word.force_z, force_word.force_y, force_word.force_x};
		end
		if (cmd.rd) begin
			site_s1 <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			ux_s1 <= wgt(off_a, off_b, off_c);
			uy_s1 <= wgt(off_b, off_a, off_c);
			uz_s1 <= wgt(off_c, off_a, off_b);
		end
	end

	assign fx_s1 = signed'(site_s1[FW-1:0]);
	assign fy_s1 = signed'(site_s1[2*FW-1:FW]);
	assign fz_s1 = signed'(site_s1[3*FW-1:2*FW]);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			pxx_s2  <= ux_s1 * fx_s1;
			pxy1_s2 <= ux_s1 * fy_s1;
			pxy2_s2 <= uy_s1 * fx_s1;
			pxz1_s2 <= ux_s1 * fz_s1;
			pxz2_s2 <= uz_s1 * fx_s1;
			pyy_s2  <= uy_s1 * fy_s1;
			pyz1_s2 <= uy_s1 * fz_s1;
			pyz2_s2 <= uz_s1 * fy_s1;
			pzz_s2  <= uz_s1 * fz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_xx_q <= '0;
			acc_xy_q <= '0;
			acc_xz_q <= '0;
			acc_yy_q <= '0;
			acc_yz_q <= '0;
			acc_zz_q <= '0;
		end else if (v_s2) begin
			acc_xx_q <= acc_xx_q + ACC_W'(pxx_s2);
			acc_xy_q <= acc_xy_q + ACC_W'(pxy1_s2) + ACC_W'(pxy2_s2);
			acc_xz_q <= acc_xz_q + ACC_W'(pxz1_s2) + ACC_W'(pxz2_s2);
			acc_yy_q <= acc_yy_q + ACC_W'(pyy_s2);
			acc_yz_q <= acc_yz_q + ACC_W'(pyz1_s2) + ACC_W'(pyz2_s2);
			acc_zz_q <= acc_zz_q + ACC_W'(pzz_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1;
		end
	end

	assign vol = VOL_W'(n) * VOL_W'(n) * VOL_W'(n);

	scg3d_div #(.ACC_W(ACC_W), .VOL_W(VOL_W)) u_div_xx (
		.clk(clk), .cmd(cmd), .acc(acc_xx_q), .off_diag(1'b0), .vol(vol), .result(r_xx));
	scg3d_div #(.ACC_W(ACC_W), .VOL_W(VOL_W)) u_div_xy (
		.clk(clk), .cmd(cmd), .acc(acc_xy_q), .off_diag(1'b1), .vol(vol), .result(r_xy));
	scg3d_div #(.ACC_W(ACC_W), .VOL_W(VOL_W)) u_div_xz (
		.clk(clk), .cmd(cmd), .acc(acc_xz_q), .off_diag(1'b1), .vol(vol), .result(r_xz));
	scg3d_div #(.ACC_W(ACC_W), .VOL_W(VOL_W)) u_div_yy (
		.clk(clk), .cmd(cmd), .acc(acc_yy_q), .off_diag(1'b0), .vol(vol), .result(r_yy));
	scg3d_div #(.ACC_W(ACC_W), .VOL_W(VOL_W)) u_div_yz (
		.clk(clk), .cmd(cmd), .acc(acc_yz_q), .off_diag(1'b1), .vol(vol), .result(r_yz));
	scg3d_div #(.ACC_W(ACC_W), .VOL_W(VOL_W)) u_div_zz (
		.clk(clk), .cmd(cmd), .acc(acc_zz_q), .off_diag(1'b0), .vol(vol), .result(r_zz));

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.stress_xx <= r_xx;
			out_q.stress_xy <= r_xy;
			out_q.stress_xz <= r_xz;
			out_q.stress_yy <= r_yy;
			out_q.stress_yz <= r_yz;
			out_q.stress_zz <= r_zz;
			out_q.last_cell <= cmd.last_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (stress_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stress_valid = out_valid_q;
	assign stress_word  = out_q;
	assign st           = '{pipe_busy: v_s1 || v_s2, out_full: out_valid_q};

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("product stage without a read stage");

	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> stress_valid)
		else $error("loaded result not presented");

endmodule
`default_nettype wire

// ===== rtl/core/stress_coarse_grain_3d_top.sv =====
// An item completing no window is taken and control stays idle; one that completes
// a window of W^3 sites gives its word after the ring read, divide and output load.
// No item is taken until the last word is loaded for output; pace is set by one ring
// read per cycle over the window and the 24-step shared-width divider lanes.
// Reset: arst_n clears position, control and registers to their defaults; the ring
// is not cleared.
`default_nettype none
module stress_coarse_grain_3d_top #(
	parameter int MAX_SIDE_X = 64,
	parameter int MAX_SIDE_Y = 64,
	parameter int MAX_SIDE_Z = 64,
	parameter int MAX_WINDOW = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [scg3d_pkg::PADDR_W-1:0]     paddr,
	input  logic [scg3d_pkg::PDATA_W-1:0]     pwdata,
	output logic [scg3d_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	input  logic                              force_valid,
	output logic                              force_ready,
	input  scg3d_pkg::force_word_t            force_word,
	output logic                              stress_valid,
	input  logic                              stress_ready,
	output scg3d_pkg::stress_word_t           stress_word
);
	import scg3d_pkg::*;

	localparam int GXW = $clog2(MAX_SIDE_X + 1);
	localparam int GYW = $clog2(MAX_SIDE_Y + 1);
	localparam int GZW = $clog2(MAX_SIDE_Z + 1);
	localparam int NW  = $clog2(MAX_WINDOW + 1);
	localparam int XW  = $clog2(MAX_SIDE_X);
	localparam int YW  = $clog2(MAX_SIDE_Y);
	localparam int ZRW = $clog2(MAX_WINDOW);
	localparam int OFW = ZRW + 1;

	logic [6:0] grid_x_q, grid_y_q, grid_z_q;
	logic [2:0] window_q;
	logic       cfg_wr;

	logic [GXW-1:0] gx;
	logic [GYW-1:0] gy;
	logic [GZW-1:0] gz;
	logic [NW-1:0]  n;

	cmd_t    cmd;
	status_t st;

	logic [XW-1:0]          wr_x, rd_x;
	logic [YW-1:0]          wr_y, rd_y;
	logic [ZRW-1:0]         wr_zr, rd_zr;
	logic signed [OFW-1:0]  off_a, off_b, off_c;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= GRID_X_RST;
			grid_y_q <= GRID_Y_RST;
			grid_z_q <= GRID_Z_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_wr) begin
			unique case (paddr)
				REG_GRID_X: grid_x_q <= pwdata[6:0];
				REG_GRID_Y: grid_y_q <= pwdata[6:0];
				REG_GRID_Z: grid_z_q <= pwdata[6:0];
				REG_WINDOW: window_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			REG_GRID_X: prdata = PDATA_W'(grid_x_q);
			REG_GRID_Y: prdata = PDATA_W'(grid_y_q);
			REG_GRID_Z: prdata = PDATA_W'(grid_z_q);
			REG_WINDOW: prdata = PDATA_W'(window_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		gx = (int'(grid_x_q) < 2) ? GXW'(2) :
			(int'(grid_x_q) > MAX_SIDE_X) ? GXW'(MAX_SIDE_X) : GXW'(grid_x_q);
		gy = (int'(grid_y_q) < 2) ? GYW'(2) :
			(int'(grid_y_q) > MAX_SIDE_Y) ? GYW'(MAX_SIDE_Y) : GYW'(grid_y_q);
		gz = (int'(grid_z_q) < 2) ? GZW'(2) :
			(int'(grid_z_q) > MAX_SIDE_Z) ? GZW'(MAX_SIDE_Z) : GZW'(grid_z_q);
		n  = (int'(window_q) < 1) ? NW'(1) :
			(int'(window_q) > MAX_WINDOW) ? NW'(MAX_WINDOW) : NW'(window_q);
	end

	scg3d_ctrl #(
		.MAX_SIDE_X(MAX_SIDE_X),
		.MAX_SIDE_Y(MAX_SIDE_Y),
		.MAX_SIDE_Z(MAX_SIDE_Z),
		.MAX_WINDOW(MAX_WINDOW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.force_valid(force_valid),
		.force_ready(force_ready),
		.first_site(force_word.first_site),
		.stress_ready(stress_ready),
		.gx(gx),
		.gy(gy),
		.gz(gz),
		.n(n),
		.st(st),
		.cmd(cmd),
		.wr_x(wr_x),
		.wr_y(wr_y),
		.wr_zr(wr_zr),
		.rd_x(rd_x),
		.rd_y(rd_y),
		.rd_zr(rd_zr),
		.off_a(off_a),
		.off_b(off_b),
		.off_c(off_c)
	);

	scg3d_dp #(
		.MAX_SIDE_X(MAX_SIDE_X),
		.MAX_SIDE_Y(MAX_SIDE_Y),
		.MAX_WINDOW(MAX_WINDOW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.force_word(force_word),
		.wr_x(wr_x),
		.wr_y(wr_y),
		.wr_zr(wr_zr),
		.rd_x(rd_x),
		.rd_y(rd_y),
		.rd_zr(rd_zr),
		.off_a(off_a),
		.off_b(off_b),
		.off_c(off_c),
		.n(n),
		.stress_ready(stress_ready),
		.stress_valid(stress_valid),
		.stress_word(stress_word)
	);

endmodule
`default_nettype wire
